[rtl/lifn_pkg.sv]
// Package with the widths, register indexes and payload types of the LIF neuron unit.
package lifn_pkg;

    localparam int VOLT_W     = 24;
    localparam int LEAK_W     = 14;
    localparam int Q_FRAC     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = VOLT_W + LEAK_W + 1;

    typedef logic signed [VOLT_W-1:0] volt_t;
    typedef logic        [LEAK_W-1:0] leak_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_RESTING   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_LEAK      = cfg_idx_t'(1);
    localparam cfg_idx_t REG_THRESHOLD = cfg_idx_t'(2);
    localparam cfg_idx_t REG_TICK_MODE = cfg_idx_t'(3);

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam volt_t VOLT_MAX   = {1'b0, {(VOLT_W-1){1'b1}}};
    localparam volt_t VOLT_MIN   = {1'b1, {(VOLT_W-1){1'b0}}};
    localparam leak_t LEAK_RESET = leak_t'(1 << Q_FRAC);

endpackage

[rtl/leaky_integrate_fire_neuron_unit.sv]
// Top level of the leaky integrate-and-fire neuron unit.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_ready   | operation, transmission
//  out     | out_valid / out_ready | spike, membrane_level
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each word goes from acceptance into the input register, then through the
// leak multiply-add (tick) or weight add (receive) and the threshold compare
// into the result register. One word is accepted every cycle while the output drains.
// A stalled output holds its word and the input register; in_ready drops only
// when both are full. The configuration port is always ready.
// Reset restores the register defaults and clears membrane and both stages.
module leaky_integrate_fire_neuron_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  lifn_pkg::volt_t       transmission,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  spike,
    output lifn_pkg::volt_t       membrane_level,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  lifn_pkg::cfg_idx_t    cfg_index,
    input  lifn_pkg::volt_t       cfg_data
);
    import lifn_pkg::*;

    // Configuration registers.
    volt_t resting_reg;
    leak_t leak_reg;
    volt_t threshold_reg;
    logic  tick_mode_reg;

    // Neuron state.
    volt_t membrane_reg, membrane_next;
    volt_t staged_reg, staged_next;
    volt_t delayed_reg, delayed_next;

    // Input register.
    logic  s1_valid_reg;
    logic  s1_op_reg;
    volt_t s1_w_reg;

    // Result register.
    logic  out_valid_reg;
    logic  spike_reg, spike_next;
    volt_t level_reg;

    logic advance;
    logic cfg_we;

    logic signed [PROD_W-1:0]          product;
    logic signed [PROD_W-Q_FRAC-1:0]   leaked;
    logic signed [PROD_W-Q_FRAC:0]     tick_sum;
    logic signed [VOLT_W:0]            recv_sum;
    logic signed [VOLT_W:0]            stage_sum;
    volt_t                             tick_val;
    volt_t                             recv_val;
    volt_t                             stage_val;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;

    assign out_valid      = out_valid_reg;
    assign spike          = spike_reg;
    assign membrane_level = level_reg;

    always_comb
    begin
        product  = $signed({1'b0, leak_reg}) * membrane_reg;
        // Arithmetic shift of the product rounds toward minus infinity.
        leaked   = product[PROD_W-1:Q_FRAC];
        tick_sum = (PROD_W-Q_FRAC+1)'(leaked) + (PROD_W-Q_FRAC+1)'(delayed_reg);
        if (tick_sum < 0)
            tick_val = '0;
        else if (tick_sum > (PROD_W-Q_FRAC+1)'(VOLT_MAX))
            tick_val = VOLT_MAX;
        else
            tick_val = tick_sum[VOLT_W-1:0];

        recv_sum = (VOLT_W+1)'(membrane_reg) + (VOLT_W+1)'(s1_w_reg);
        if (recv_sum > (VOLT_W+1)'(VOLT_MAX))
            recv_val = VOLT_MAX;
        else if (recv_sum < (VOLT_W+1)'(VOLT_MIN))
            recv_val = VOLT_MIN;
        else
            recv_val = recv_sum[VOLT_W-1:0];

        stage_sum = (VOLT_W+1)'(staged_reg) + (VOLT_W+1)'(s1_w_reg);
        if (stage_sum > (VOLT_W+1)'(VOLT_MAX))
            stage_val = VOLT_MAX;
        else if (stage_sum < (VOLT_W+1)'(VOLT_MIN))
            stage_val = VOLT_MIN;
        else
            stage_val = stage_sum[VOLT_W-1:0];

        membrane_next = membrane_reg;
        staged_next   = staged_reg;
        delayed_next  = delayed_reg;
        spike_next    = 1'b0;

        case (s1_op_reg)
            OP_TICK:
            begin
                delayed_next  = staged_reg;
                staged_next   = '0;
                membrane_next = tick_val;
                spike_next    = tick_val > threshold_reg;
            end
            default:
            begin
                if (tick_mode_reg)
                begin
                    staged_next = stage_val;
                end
                else
                begin
                    membrane_next = recv_val;
                    spike_next    = recv_val > threshold_reg;
                end
            end
        endcase

        if (spike_next)
            membrane_next = resting_reg;
    end

    // Configuration and neuron state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resting_reg   <= '0;
            leak_reg      <= LEAK_RESET;
            threshold_reg <= '0;
            tick_mode_reg <= 1'b1;
            membrane_reg  <= '0;
            staged_reg    <= '0;
            delayed_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                staged_reg   <= staged_next;
                delayed_reg  <= delayed_next;
            end
            // Writing the resting level also loads the membrane.
            if (cfg_we && cfg_index == REG_RESTING)
                membrane_reg <= cfg_data;
            else if (advance)
                membrane_reg <= membrane_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RESTING:   resting_reg   <= cfg_data;
                    REG_LEAK:      leak_reg      <= cfg_data[LEAK_W-1:0];
                    REG_THRESHOLD: threshold_reg <= cfg_data;
                    REG_TICK_MODE: tick_mode_reg <= cfg_data[0];
                    default:       ;
                endcase
            end
        end
    end

    // Valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg <= operation;
            s1_w_reg  <= transmission;
        end
        if (advance)
        begin
            spike_reg <= spike_next;
            level_reg <= membrane_next;
        end
    end

    // A tick always empties the staging sum.
    a_tick_clears_stage: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_op_reg == OP_TICK |=> staged_reg == '0)
        else $error("staging sum not cleared by tick");

    // A staged receive leaves the membrane untouched.
    a_staged_keeps_membrane: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_op_reg == OP_RECEIVE && tick_mode_reg && !cfg_we
        |=> $stable(membrane_reg))
        else $error("staged receive changed membrane");

    // An empty result register never stalls the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output");

    // A word taken while the input register is full must move on the same edge.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && s1_valid_reg |-> advance)
        else $error("input register overwritten");

endmodule
